>>> rtl/fisr_pkg.sv
// fisr_pkg: constants, types and binary32 normalize/round helpers.
// Shared by fisr_fmul, fisr_fadd and fast_inverse_square_root_core; no dependencies.
package fisr_pkg;

  localparam logic [31:0] MAGIC      = 32'h5f3759df;
  localparam logic [31:0] CANON_NAN  = 32'h7FC00000;
  localparam logic [31:0] HALF       = 32'h3F000000;
  localparam logic [31:0] THREE_HALF = 32'h3FC00000;
  localparam int          GDLY       = 13;

  typedef enum logic [3:0] {
    CLS_NUM  = 4'b0001,
    CLS_ZERO = 4'b0010,
    CLS_INF  = 4'b0100,
    CLS_NAN  = 4'b1000
  } cls_t;

  typedef struct packed {
    logic        sign;
    cls_t        cls;
    logic        ovf;
    logic [7:0]  efield;
    logic [22:0] frac;
    logic        rnd;
    logic        stk;
  } rnd_t;

  function automatic logic [5:0] lzc64(input logic [63:0] w);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found && w[i]) begin
        found = 1'b1;
        n     = 6'(63 - i);
      end
    end
    return n;
  endfunction

  // w carries the unit bit at position 62; value = w * 2^(e_in - 127 - 62)
  function automatic rnd_t norm(input logic sign, input cls_t cls,
                                input logic [63:0] w, input logic signed [11:0] e_in);
    logic [5:0]          lz;
    logic signed [11:0]  e;
    logic signed [11:0]  s;
    logic signed [11:0]  ns;
    logic [63:0]         n;
    logic [127:0]        wide;
    logic [6:0]          rs;
    logic                stk;
    rnd_t                r;
    lz   = lzc64(w);
    e    = e_in + 12'sd1 - signed'({6'b0, lz});
    stk  = 1'b0;
    s    = 12'sd0;
    ns   = 12'sd0;
    rs   = 7'd0;
    wide = 128'b0;
    if (e >= 12'sd1) begin
      n = w << lz;
    end else begin
      s = signed'({6'b0, lz}) + e - 12'sd1;
      if (s >= 12'sd0) begin
        n = w << s[5:0];
      end else begin
        ns   = -s;
        rs   = (ns > 12'sd64) ? 7'd64 : ns[6:0];
        wide = {w, 64'b0} >> rs;
        n    = wide[127:64];
        stk  = |wide[63:0];
      end
    end
    r.sign   = sign;
    r.cls    = cls;
    r.ovf    = (e >= 12'sd255);
    r.efield = (e >= 12'sd1) ? e[7:0] : 8'd0;
    r.frac   = n[62:40];
    r.rnd    = n[39];
    r.stk    = stk | (|n[38:0]);
    return r;
  endfunction

  // round to nearest even and pack; any NaN leaves as the canonical quiet NaN
  function automatic logic [31:0] round_pack(input rnd_t r);
    logic        up;
    logic [30:0] p;
    logic [31:0] y;
    up = r.rnd & (r.stk | r.frac[0]);
    p  = {r.efield, r.frac} + {30'b0, up};
    case (r.cls)
      CLS_NAN:  y = CANON_NAN;
      CLS_INF:  y = {r.sign, 8'hFF, 23'b0};
      CLS_ZERO: y = {r.sign, 31'b0};
      default: begin
        if (r.ovf) y = {r.sign, 8'hFF, 23'b0};
        else       y = {r.sign, p};
      end
    endcase
    return y;
  endfunction

endpackage

>>> rtl/fisr_fmul.sv
// fisr_fmul: three-stage binary32 multiplier (product, normalize, round).
// Depends on fisr_pkg.
module fisr_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] y
);

  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  fisr_pkg::cls_t cls_nxt;

  logic               v1_r, v2_r, v3_r;
  logic               sign1_r;
  fisr_pkg::cls_t     cls1_r;
  logic signed [11:0] e1_r;
  logic [47:0]        p1_r;
  fisr_pkg::rnd_t     n2_r;
  logic [31:0]        y_r;

  always_comb begin
    ea     = a[30:23];
    eb     = b[30:23];
    ea_eff = (ea == 8'd0) ? 8'd1 : ea;
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    ma     = {ea != 8'd0, a[22:0]};
    mb     = {eb != 8'd0, b[22:0]};
    nan_a  = (ea == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (eb == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (ea == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (eb == 8'hFF) && (b[22:0] == 23'd0);
    zero_a = (ea == 8'd0) && (a[22:0] == 23'd0);
    zero_b = (eb == 8'd0) && (b[22:0] == 23'd0);
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) cls_nxt = fisr_pkg::CLS_NAN;
    else if (inf_a || inf_b)                                      cls_nxt = fisr_pkg::CLS_INF;
    else if (zero_a || zero_b)                                    cls_nxt = fisr_pkg::CLS_ZERO;
    else                                                          cls_nxt = fisr_pkg::CLS_NUM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sign1_r <= a[31] ^ b[31];
      cls1_r  <= cls_nxt;
      e1_r    <= signed'({4'b0, ea_eff}) + signed'({4'b0, eb_eff}) - 12'sd127;
      p1_r    <= ma * mb;
      n2_r    <= fisr_pkg::norm(sign1_r, cls1_r, {p1_r, 16'b0}, e1_r);
      y_r     <= fisr_pkg::round_pack(n2_r);
    end
  end

  assign out_vld = v3_r;
  assign y       = y_r;

endmodule

>>> rtl/fisr_fadd.sv
// fisr_fadd: four-stage binary32 adder (align, add, normalize, round).
// Depends on fisr_pkg.
module fisr_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_vld,
  output logic [31:0] y
);

  logic [31:0]  x, z;
  logic [7:0]   ex, ez, ex_eff, ez_eff, d;
  logic [23:0]  mx, mz;
  logic [99:0]  wide;
  logic [50:0]  zal;
  logic         stk;
  logic         nan_a, nan_b, inf_a, inf_b;
  fisr_pkg::cls_t cls_nxt;
  logic [50:0]  sum;
  fisr_pkg::cls_t cls2_nxt;

  logic           v1_r, v2_r, v3_r, v4_r;
  fisr_pkg::cls_t cls1_r, cls2_r;
  logic           sx1_r, sub1_r, sign2_r;
  logic [7:0]     ex1_r, ex2_r;
  logic [50:0]    xm1_r, zm1_r, sum2_r;
  fisr_pkg::rnd_t n3_r;
  logic [31:0]    y_r;

  always_comb begin
    if (b[30:0] > a[30:0]) begin
      x = b;
      z = a;
    end else begin
      x = a;
      z = b;
    end
    ex     = x[30:23];
    ez     = z[30:23];
    ex_eff = (ex == 8'd0) ? 8'd1 : ex;
    ez_eff = (ez == 8'd0) ? 8'd1 : ez;
    mx     = {ex != 8'd0, x[22:0]};
    mz     = {ez != 8'd0, z[22:0]};
    d      = ex_eff - ez_eff;
    wide   = 100'b0;
    if (d >= 8'd50) begin
      zal = 51'b0;
      stk = |mz;
    end else begin
      wide = {mz, 76'b0} >> d;
      zal  = {1'b0, wide[99:50]};
      stk  = |wide[49:0];
    end
    zal[0] = zal[0] | stk;
    nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (nan_a || nan_b || (inf_a && inf_b && (a[31] != b[31]))) cls_nxt = fisr_pkg::CLS_NAN;
    else if (inf_a || inf_b)                                    cls_nxt = fisr_pkg::CLS_INF;
    else                                                        cls_nxt = fisr_pkg::CLS_NUM;

    sum      = sub1_r ? (xm1_r - zm1_r) : (xm1_r + zm1_r);
    cls2_nxt = (cls1_r == fisr_pkg::CLS_NUM && sum == 51'd0) ? fisr_pkg::CLS_ZERO : cls1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls1_r  <= cls_nxt;
      sx1_r   <= x[31];
      sub1_r  <= x[31] ^ z[31];
      ex1_r   <= ex_eff;
      xm1_r   <= {1'b0, mx, 26'b0};
      zm1_r   <= zal;
      cls2_r  <= cls2_nxt;
      // exact cancellation gives +0
      sign2_r <= (cls2_nxt == fisr_pkg::CLS_ZERO && sub1_r) ? 1'b0 : sx1_r;
      ex2_r   <= ex1_r;
      sum2_r  <= sum;
      n3_r    <= fisr_pkg::norm(sign2_r, cls2_r, {sum2_r, 13'b0}, signed'({4'b0, ex2_r}));
      y_r     <= fisr_pkg::round_pack(n3_r);
    end
  end

  assign out_vld = v4_r;
  assign y       = y_r;

endmodule

>>> rtl/fast_inverse_square_root_core.sv
// fast_inverse_square_root_core: binary32 1/sqrt(x), magic-constant guess plus one Newton step.
// Pipeline of four 3-stage multipliers and one 4-stage adder in series;
// throughput one transaction per cycle; a stall at the output freezes the whole pipeline.
// Reset (synchronous, rst_n low) clears all valid bits; no other state.
// Depends on fisr_pkg, fisr_fmul, fisr_fadd.
module fast_inverse_square_root_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] result_bits
);

  logic        en;
  logic [31:0] g_dly_r [fisr_pkg::GDLY];
  logic        v_half, v_p1, v_p2, v_corr;
  logic [31:0] halfx, p1, p2, corr;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (en) begin
      g_dly_r[0] <= fisr_pkg::MAGIC - {1'b0, in_tdata[31:1]};
      for (int i = 1; i < fisr_pkg::GDLY; i++) g_dly_r[i] <= g_dly_r[i-1];
    end
  end

  fisr_fmul u_half (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_tvalid),
    .a(in_tdata), .b(fisr_pkg::HALF), .out_vld(v_half), .y(halfx)
  );

  fisr_fmul u_p1 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_half),
    .a(halfx), .b(g_dly_r[2]), .out_vld(v_p1), .y(p1)
  );

  fisr_fmul u_p2 (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_p1),
    .a(p1), .b(g_dly_r[5]), .out_vld(v_p2), .y(p2)
  );

  fisr_fadd u_corr (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_p2),
    .a(fisr_pkg::THREE_HALF), .b({~p2[31], p2[30:0]}), .out_vld(v_corr), .y(corr)
  );

  fisr_fmul u_res (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v_corr),
    .a(g_dly_r[12]), .b(corr), .out_vld(out_tvalid), .y(out_tdata)
  );

  a_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[30:23] == 8'hFF && out_tdata[22:0] != 23'd0
      |-> out_tdata == fisr_pkg::CANON_NAN)
    else $error("non-canonical NaN on output");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for fast_inverse_square_root_core (binary32 rsqrt).
// Bit-exact software float predictor, random handshake idling; depends on the core RTL only.
module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;

  localparam logic [31:0] QNAN    = 32'h7FC00000;
  localparam logic [31:0] ONE_HALF = 32'h3F000000;
  localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
  localparam logic [31:0] GUESS_MAGIC = 32'h5f3759df;
  localparam int NUM_RANDOM = 1400;

  logic [31:0] pending_values[$];
  logic [31:0] expected_rsqrt[$];
  int          errors;
  int          sent;
  int          hold_cycles;
  bit          held_once;

  fast_inverse_square_root_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  function automatic bit is_nan(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return a[30:23] == 8'hFF && a[22:0] == 0;
  endfunction

  function automatic void split(input logic [31:0] a, output longint m, output int e);
    if (a[30:23] == 0) begin
      m = a[22:0];
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  // value = m * 2^e, m nonzero; round to nearest even with gradual underflow
  function automatic logic [31:0] pack_rne(input logic s, input logic [63:0] m, input int e);
    int           p;
    int           sh;
    int           lsb;
    logic [127:0] w;
    logic [63:0]  q;
    logic         rb;
    logic         st;
    int           fld;
    p = 0;
    for (int i = 0; i < 64; i++) if (m[i]) p = i;
    sh = (p - 23 > -149 - e) ? p - 23 : -149 - e;
    if (sh > 64) begin
      q = 0; rb = 0; st = 1;
    end else if (sh > 0) begin
      w  = {m, 64'b0} >> sh;
      q  = w[127:64];
      rb = w[63];
      st = |w[62:0];
    end else begin
      q = m << (-sh); rb = 0; st = 0;
    end
    if (rb && (st || q[0])) q = q + 1;
    lsb = e + sh;
    if (q >= 64'h100_0000) begin
      q = q >> 1;
      lsb++;
    end
    if (q >= 64'h80_0000) begin
      fld = lsb + 150;
      if (fld >= 255) return {s, 8'hFF, 23'b0};
      return {s, fld[7:0], q[22:0]};
    end
    return {s, 8'b0, q[22:0]};
  endfunction

  function automatic logic [31:0] f32_mul(input logic [31:0] a, input logic [31:0] b);
    longint ma, mb;
    int     ea, eb;
    logic   s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNAN;
    split(a, ma, ea);
    split(b, mb, eb);
    if (is_inf(a) || is_inf(b)) begin
      if ((!is_inf(a) && ma == 0) || (!is_inf(b) && mb == 0)) return QNAN;
      return {s, 8'hFF, 23'b0};
    end
    if (ma == 0 || mb == 0) return {s, 31'b0};
    return pack_rne(s, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] f32_sub(input logic [31:0] a, input logic [31:0] bin);
    logic [31:0] b;
    longint      ma, mb, sum;
    int          ea, eb, lo;
    b = {~bin[31], bin[30:0]};
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    split(a, ma, ea);
    split(b, mb, eb);
    if (ma == 0 && mb == 0) return {a[31] & b[31], 31'b0};
    if (ma == 0) return b;
    if (mb == 0) return a;
    // far smaller operand only contributes as sticky
    if (ea - eb > 36) begin
      mb = 1; eb = ea - 36;
    end else if (eb - ea > 36) begin
      ma = 1; ea = eb - 36;
    end
    lo  = (ea < eb) ? ea : eb;
    ma  = ma << (ea - lo);
    mb  = mb << (eb - lo);
    sum = (a[31] ? -ma : ma) + (b[31] ? -mb : mb);
    if (sum == 0) return 32'b0;
    return pack_rne(sum < 0, (sum < 0) ? -sum : sum, lo);
  endfunction

  function automatic logic [31:0] rsqrt_predict(input logic [31:0] x);
    logic [31:0] g, hx, p1, p2, corr;
    g    = GUESS_MAGIC - (x >> 1);
    hx   = f32_mul(x, ONE_HALF);
    p1   = f32_mul(hx, g);
    p2   = f32_mul(p1, g);
    corr = f32_sub(THREE_HALVES, p2);
    return f32_mul(g, corr);
  endfunction

  task automatic report(input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: result_bits got %08h expected %08h", got, want);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
  end

  initial begin
    logic [31:0] v;
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
                 32'h4080_0000, 32'hBF80_0000, 32'h5F37_59DF, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h8000_0001, 32'h0040_0000, 32'h3E80_0000};
    foreach (directed[i]) pending_values.push_back(directed[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
        2: v = {1'($urandom), 8'h00, 23'($urandom)};
        default: v = {1'($urandom), ($urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(0, 3))),
                      23'($urandom)};
      endcase
      pending_values.push_back(v);
    end
  end

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata  <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_values.size() != 0 &&
          !(sent < 470 && $urandom_range(0, 99) < 35) &&
          !(sent >= 470 && sent < 940 && $urandom_range(0, 99) < 88)) begin
        in_tvalid <= 1;
        in_tdata  <= pending_values[0];
        expected_rsqrt.push_back(rsqrt_predict(pending_values[0]));
        void'(pending_values.pop_front());
        sent++;
      end else begin
        in_tvalid <= 0;
      end
    end
  end

  // receiver, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_cycles > 0) begin
      out_tready  <= 0;
      hold_cycles <= hold_cycles - 1;
    end else if (!held_once && sent >= 1100) begin
      held_once   <= 1;
      hold_cycles <= 200;
      out_tready  <= 0;
    end else if (sent < 470) begin
      out_tready <= $urandom_range(0, 99) >= 88;
    end else if (sent < 940) begin
      out_tready <= $urandom_range(0, 99) >= 35;
    end else begin
      out_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rsqrt.size() == 0) begin
        report(out_tdata, 32'hxxxx_xxxx);
      end else begin
        if (out_tdata !== expected_rsqrt[0]) report(out_tdata, expected_rsqrt[0]);
        void'(expected_rsqrt.pop_front());
      end
    end
  end

  initial begin
    errors = 0; sent = 0; hold_cycles = 0; held_once = 0;
    @(posedge rst_n);
    wait (pending_values.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    wait (expected_rsqrt.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_rsqrt.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
